### hw/rtl/grid_nest_distance_field_defines.svh
// Assertion macros for the nest distance field block.
// Standalone header: no dependencies; included by files that carry assertions.
`ifndef GRID_NEST_DISTANCE_FIELD_DEFINES_SVH
`define GRID_NEST_DISTANCE_FIELD_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define GNDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define GNDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gndf_pkg.sv
// Shared constants, types and level helpers for the nest distance field block.
// No dependencies; imported by grid_nest_distance_field.
package gndf_pkg;

    localparam int GRID_SIZE = 64;
    localparam int GRID_W    = $clog2(GRID_SIZE);
    localparam int CELL_W    = 2 * GRID_W;
    localparam int LEVEL_W   = $clog2(GRID_SIZE + 1);

    typedef logic [GRID_W-1:0]  t_coord;
    typedef logic [CELL_W-1:0]  t_cell;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [1:0]         t_kind;

    localparam t_kind KIND_MARK = 2'd0;
    localparam t_kind KIND_RUN  = 2'd1;
    localparam t_kind KIND_READ = 2'd2;

    localparam t_cell  CELL_LAST  = t_cell'(GRID_SIZE * GRID_SIZE - 1);
    localparam t_coord COORD_LAST = t_coord'(GRID_SIZE - 1);
    localparam t_level LEVEL_FULL = t_level'(GRID_SIZE);

    // Level a neighbor hands on: one less, floored at zero.
    function automatic t_level level_offer(input t_level v);
        return (v == '0) ? '0 : v - t_level'(1);
    endfunction

    function automatic t_level level_max(input t_level a, input t_level b);
        return (a > b) ? a : b;
    endfunction

endpackage

### hw/rtl/grid_nest_distance_field.sv
// Top level of the nest distance field block: cell memories, sweep engine, result register.
// Depends on gndf_pkg and grid_nest_distance_field_defines.svh.
`include "grid_nest_distance_field_defines.svh"

// Nest distance field over a 64 x 64 grid. Two single-port-read, single-port-write memories
// hold the nest mark and the level of every cell. After reset the block runs a clearing pass
// over all 4096 cells that zeroes both memories; it accepts no beat until that pass is over. A
// mark beat gives no result. A read beat does the memory read, then the load of the result
// register. A run beat does a forward raster sweep of all 4096 cells that loads each nest cell
// at full level and pulls levels from the upper and left neighbors, then a backward sweep that
// pulls from the lower and right neighbors. Each sweep handles one cell per cycle, set by the
// one read and one write port of the level memory; a 65-entry line of the most recently
// finished levels feeds the neighbor terms, so every cell is read once and written once per
// sweep. The backward sweep starts only once the last write of the forward one has landed, which
// keeps its first read off that write. The result register decouples the output side: a finished
// result waits there while mark beats are still taken. Kind 3 is dropped.
module grid_nest_distance_field (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gndf_pkg::t_kind  i_kind,
    input  gndf_pkg::t_coord i_row,
    input  gndf_pkg::t_coord i_col,
    input  logic             i_nest,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output gndf_pkg::t_level o_level,
    output logic             o_is_nest,
    output logic             o_run_done
);
    import gndf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FWD,
        S_BWD,
        S_RESULT
    } t_state;

    // Control registers.
    t_state r_state, n_state;
    t_cell  r_scan, n_scan;         // clear address or sweep issue position
    logic   r_issue, n_issue;       // sweep still issuing reads
    logic   r_p1_valid, n_p1_valid; // read data of a sweep cell is back
    logic   r_out_valid, n_out_valid;

    // Payload registers.
    t_cell  r_p1_scan, n_p1_scan;
    logic   r_is_run, n_is_run;
    t_level r_out_level, n_out_level;
    logic   r_out_nest, n_out_nest;
    logic   r_out_done, n_out_done;
    t_level r_line [0:GRID_SIZE];   // finished levels, newest at index 0
    t_level n_line [0:GRID_SIZE];

    // Memories and their registered read data.
    t_level r_lvl_mem  [0:GRID_SIZE*GRID_SIZE-1];
    logic   r_nest_mem [0:GRID_SIZE*GRID_SIZE-1];
    t_level r_level_q;
    logic   r_nest_q;

    logic   in_accept;
    logic   in_sweep;
    logic   rd_en;
    t_cell  rd_addr;
    logic   lvl_we;
    t_cell  lvl_waddr;
    t_level lvl_wdata;
    logic   nest_we;
    t_cell  nest_waddr;
    logic   nest_wdata;

    // Neighbor terms of the cell in stage one.
    logic   on_top, on_first, on_last;
    t_level own, off_side, off_diag_near, off_vert, off_diag_far, lvl_new;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_sweep    = (r_state == S_FWD) || (r_state == S_BWD);
    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_is_nest   = r_out_nest;
    assign o_run_done  = r_out_done;

    // Scan position runs in raster order; the backward sweep mirrors the address, so the
    // same line taps and edge tests serve both sweeps.
    assign on_top   = (r_p1_scan[CELL_W-1:GRID_W] == '0);
    assign on_first = (r_p1_scan[GRID_W-1:0] == '0);
    assign on_last  = (r_p1_scan[GRID_W-1:0] == COORD_LAST);

    always_comb begin
        // Forward sweep seeds nest cells at full level; backward sweep starts from memory.
        own           = (r_state == S_FWD) ? (r_nest_q ? LEVEL_FULL : '0) : r_level_q;
        off_side      = on_first ? '0 : level_offer(r_line[0]);
        off_diag_near = (on_top || on_last) ? '0 : level_offer(r_line[GRID_SIZE-2]);
        off_vert      = on_top ? '0 : level_offer(r_line[GRID_SIZE-1]);
        off_diag_far  = (on_top || on_first) ? '0 : level_offer(r_line[GRID_SIZE]);
        lvl_new       = level_max(level_max(own, off_side),
                                  level_max(level_max(off_diag_near, off_vert), off_diag_far));
    end

    // Memory port steering.
    always_comb begin
        rd_en      = (in_accept && (i_kind == KIND_READ)) || (in_sweep && r_issue);
        rd_addr    = {i_row, i_col};
        if (in_sweep) begin
            rd_addr = (r_state == S_BWD) ? ~r_scan : r_scan;
        end

        lvl_we     = (r_state == S_CLEAR) || (in_sweep && r_p1_valid);
        lvl_waddr  = r_scan;
        lvl_wdata  = '0;
        if (in_sweep) begin
            lvl_waddr = (r_state == S_BWD) ? ~r_p1_scan : r_p1_scan;
            lvl_wdata = lvl_new;
        end

        nest_we    = (r_state == S_CLEAR) || (in_accept && (i_kind == KIND_MARK));
        nest_waddr = (r_state == S_CLEAR) ? r_scan : {i_row, i_col};
        nest_wdata = (r_state == S_CLEAR) ? 1'b0 : i_nest;
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        if (rd_en) begin
            r_level_q <= r_lvl_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nest_we) begin
            r_nest_mem[nest_waddr] <= nest_wdata;
        end
        if (rd_en) begin
            r_nest_q <= r_nest_mem[rd_addr];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_issue     = r_issue;
        n_p1_valid  = r_p1_valid;
        n_out_valid = r_out_valid;
        n_p1_scan   = r_p1_scan;
        n_is_run    = r_is_run;
        n_out_level = r_out_level;
        n_out_nest  = r_out_nest;
        n_out_done  = r_out_done;
        n_line      = r_line;

        // Drop the result once the output side takes the beat.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_scan = r_scan + t_cell'(1);
                if (r_scan == CELL_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_kind)
                        KIND_RUN: begin
                            n_state  = S_FWD;
                            n_scan   = '0;
                            n_issue  = 1'b1;
                            n_is_run = 1'b1;
                        end
                        KIND_READ: begin
                            n_state  = S_RESULT;
                            n_is_run = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FWD, S_BWD: begin
                // Stage zero: issue the read of the next cell.
                n_p1_valid = r_issue;
                if (r_issue) begin
                    n_p1_scan = r_scan;
                    n_scan    = r_scan + t_cell'(1);
                    if (r_scan == CELL_LAST) begin
                        n_issue = 1'b0;
                    end
                end
                // Stage one: the finished level enters the line as it is written back.
                if (r_p1_valid) begin
                    for (int i = GRID_SIZE; i > 0; i--) begin
                        n_line[i] = r_line[i-1];
                    end
                    n_line[0] = lvl_new;
                end
                // Sweep over once the last write has landed.
                if (!r_issue && !r_p1_valid) begin
                    if (r_state == S_FWD) begin
                        n_state = S_BWD;
                        n_scan  = '0;
                        n_issue = 1'b1;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                // Hold until the result register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_is_run ? '0 : r_level_q;
                    n_out_nest  = r_is_run ? 1'b0 : r_nest_q;
                    n_out_done  = r_is_run;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p1_scan   <= n_p1_scan;
        r_is_run    <= n_is_run;
        r_out_level <= n_out_level;
        r_out_nest  <= n_out_nest;
        r_out_done  <= n_out_done;
        r_line      <= n_line;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_issue     <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_issue     <= n_issue;
            r_p1_valid  <= n_p1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    `GNDF_ASSERT_IMP(a_level_in_range, i_clk, i_rst_n, in_sweep && r_p1_valid, lvl_new <= LEVEL_FULL, "sweep level above full level")
    `GNDF_ASSERT_IMP(a_bwd_never_falls, i_clk, i_rst_n, (r_state == S_BWD) && r_p1_valid, lvl_new >= r_level_q, "backward sweep lowered a level")
    `GNDF_ASSERT_IMP(a_sweep_no_overlap, i_clk, i_rst_n, in_sweep && r_issue && lvl_we, rd_addr != lvl_waddr, "sweep read hits the entry being written")
    `GNDF_ASSERT_NXT(a_result_waits, i_clk, i_rst_n, (r_state == S_RESULT) && r_out_valid && i_out_stall, r_state == S_RESULT, "result left while output register busy")

endmodule

### dv/gndf_field_checker.sv
// Checker for the nest distance field block: watches both channels, predicts, compares.
// Depends on gndf_pkg; instantiated by tb_top beside the block.
module gndf_field_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  gndf_pkg::t_kind  i_kind,
    input  gndf_pkg::t_coord i_row,
    input  gndf_pkg::t_coord i_col,
    input  logic             i_nest,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  gndf_pkg::t_level i_level,
    input  logic             i_is_nest,
    input  logic             i_run_done,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE  = gndf_pkg::GRID_SIZE;
    localparam int CELLS = SIDE * SIDE;

    typedef struct packed {
        gndf_pkg::t_level level;
        logic             is_nest;
        logic             run_done;
    } cell_result_t;

    logic         nest_marks [CELLS];
    int           field_level [CELLS];
    cell_result_t expected_results [$];

    // Level a neighbor hands on; zero off the grid.
    function automatic int neighbor_offer(input int r, input int c);
        int v;
        if (r < 0 || r >= SIDE || c < 0 || c >= SIDE) return 0;
        v = field_level[r * SIDE + c] - 1;
        return (v > 0) ? v : 0;
    endfunction

    function automatic void raise_level(input int r, input int c, input int v);
        if (v > field_level[r * SIDE + c]) field_level[r * SIDE + c] = v;
    endfunction

    // Seed nests at full level, then one forward and one backward raster pass.
    function automatic void spread_field();
        int m;
        for (int i = 0; i < CELLS; i++) field_level[i] = nest_marks[i] ? SIDE : 0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                m = neighbor_offer(r - 1, c - 1);
                if (neighbor_offer(r - 1, c) > m)     m = neighbor_offer(r - 1, c);
                if (neighbor_offer(r - 1, c + 1) > m) m = neighbor_offer(r - 1, c + 1);
                if (neighbor_offer(r, c - 1) > m)     m = neighbor_offer(r, c - 1);
                raise_level(r, c, m);
            end
        end
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                m = neighbor_offer(r + 1, c + 1);
                if (neighbor_offer(r + 1, c) > m)     m = neighbor_offer(r + 1, c);
                if (neighbor_offer(r + 1, c - 1) > m) m = neighbor_offer(r + 1, c - 1);
                if (neighbor_offer(r, c + 1) > m)     m = neighbor_offer(r, c + 1);
                raise_level(r, c, m);
            end
        end
    endfunction

    // 6-bit coordinates always land on the 64-wide grid.
    function automatic void predict_beat(input gndf_pkg::t_kind kind, input gndf_pkg::t_coord row,
                                         input gndf_pkg::t_coord col, input logic nest);
        cell_result_t res;
        int           idx;
        idx = int'(row) * SIDE + int'(col);
        case (kind)
            gndf_pkg::KIND_MARK: begin
                nest_marks[idx] = nest;
            end
            gndf_pkg::KIND_RUN: begin
                spread_field();
                res.level    = '0;
                res.is_nest  = 1'b0;
                res.run_done = 1'b1;
                expected_results.push_back(res);
            end
            gndf_pkg::KIND_READ: begin
                res.level    = gndf_pkg::t_level'(field_level[idx]);
                res.is_nest  = nest_marks[idx];
                res.run_done = 1'b0;
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    // Clear the model in reset. Retire the output beat before taking the input beat
    // of the same edge.
    always @(posedge i_clk) begin
        cell_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                nest_marks[i]  = 1'b0;
                field_level[i] = 0;
            end
            expected_results.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, actual %0d %0d %0d",
                             $time, i_level, i_is_nest, i_run_done);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("level", want.level, i_level);
                    compare_field("is_nest", want.is_nest, i_is_nest);
                    compare_field("run_done", want.run_done, i_run_done);
                end
            end
            if (i_in_valid && !i_in_stall) predict_beat(i_kind, i_row, i_col, i_nest);
            o_pending = expected_results.size();
        end
    end

endmodule

### dv/tb_top.sv
// Top of the nest distance field testbench: clock, reset, stimulus, receiver, verdict.
// Depends on gndf_pkg, grid_nest_distance_field and gndf_field_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;  // above the length of a run or of the clearing pass
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 115;
    localparam int LAST          = gndf_pkg::GRID_SIZE - 1;
    localparam int MAX_NESTS     = 8;

    // Kind 3 has no name in the package; the block drops it.
    localparam gndf_pkg::t_kind KIND_UNUSED = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    gndf_pkg::t_kind  i_kind;
    gndf_pkg::t_coord i_row;
    gndf_pkg::t_coord i_col;
    logic             i_nest;
    logic             o_out_valid;
    logic             i_out_stall;
    gndf_pkg::t_level o_level;
    logic             o_is_nest;
    logic             o_run_done;

    int chk_fail_count;
    int chk_pending;
    int idle_cycles = 0;

    // Shared between the sender and the receiver process.
    bit idle_en       = 1'b1;
    bit long_hold_req = 1'b0;

    // Nests placed so far, seeded with the directed ones, used to aim reads near them.
    int nest_rows [$];
    int nest_cols [$];

    grid_nest_distance_field u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_nest      (i_nest),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_level     (o_level),
        .o_is_nest   (o_is_nest),
        .o_run_done  (o_run_done)
    );

    gndf_field_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_nest       (i_nest),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_level      (o_level),
        .i_is_nest    (o_is_nest),
        .i_run_done   (o_run_done),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: stall in short random bursts, or hold off for a long stretch on request.
    // At most one assignment to the stall per falling edge.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > LAST) return LAST;
        return v;
    endfunction

    // Offer one beat. Call at a falling edge; return at the falling edge after acceptance
    // with valid still high, so consecutive beats drop valid in between only for a random gap.
    task automatic send_beat(input gndf_pkg::t_kind kind, input int row, input int col,
                             input logic nest);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_row      <= gndf_pkg::t_coord'(row);
        i_col      <= gndf_pkg::t_coord'(col);
        i_nest     <= nest;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Read a cell a few steps from a placed nest, or anywhere when none is placed.
    task automatic read_cell(input bit aim_near);
        int k;
        if (aim_near && nest_rows.size() != 0) begin
            k = $urandom_range(0, nest_rows.size() - 1);
            send_beat(gndf_pkg::KIND_READ,
                      clamp_coord(nest_rows[k] + $urandom_range(0, 8) - 4),
                      clamp_coord(nest_cols[k] + $urandom_range(0, 8) - 4),
                      1'($urandom_range(0, 1)));
        end else begin
            send_beat(gndf_pkg::KIND_READ, $urandom_range(0, LAST), $urandom_range(0, LAST),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int sent;
        int group;
        int n_marks;
        int k;
        int r;
        int c;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_kind     = gndf_pkg::KIND_MARK;
        i_row      = '0;
        i_col      = '0;
        i_nest     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, a run with no nests, corners, a cleared mark, the unused
        // kind, and a mark that must not move levels before the next run.
        send_beat(gndf_pkg::KIND_READ, 0, 0, 1'b0);
        send_beat(gndf_pkg::KIND_RUN, 0, 0, 1'b0);
        send_beat(gndf_pkg::KIND_READ, LAST, LAST, 1'b1);
        send_beat(gndf_pkg::KIND_MARK, 0, 0, 1'b1);
        send_beat(gndf_pkg::KIND_MARK, LAST, LAST, 1'b1);
        send_beat(gndf_pkg::KIND_MARK, 0, LAST, 1'b1);
        send_beat(gndf_pkg::KIND_MARK, 0, LAST, 1'b0);
        send_beat(KIND_UNUSED, 5, 5, 1'b1);
        send_beat(gndf_pkg::KIND_RUN, LAST, LAST, 1'b1);
        send_beat(gndf_pkg::KIND_READ, 0, 0, 1'b0);
        send_beat(gndf_pkg::KIND_READ, 0, 1, 1'b0);
        send_beat(gndf_pkg::KIND_READ, LAST, LAST, 1'b0);
        send_beat(gndf_pkg::KIND_READ, 0, LAST, 1'b0);
        send_beat(gndf_pkg::KIND_READ, 32, 32, 1'b0);
        send_beat(gndf_pkg::KIND_READ, LAST, 0, 1'b0);
        send_beat(gndf_pkg::KIND_MARK, 31, 31, 1'b1);
        send_beat(gndf_pkg::KIND_READ, 31, 31, 1'b0);
        send_beat(gndf_pkg::KIND_RUN, 0, 0, 1'b0);
        send_beat(gndf_pkg::KIND_READ, 31, 31, 1'b0);
        send_beat(gndf_pkg::KIND_READ, 30, 33, 1'b0);
        send_beat(gndf_pkg::KIND_MARK, 0, 0, 1'b0);
        send_beat(gndf_pkg::KIND_READ, 0, 0, 1'b0);
        nest_rows = '{LAST, 31};
        nest_cols = '{LAST, 31};

        // Random: mostly mark, run, read groups with random content, plus stray noise.
        sent  = 0;
        group = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent > RANDOM_ITEMS - 30) idle_en = 1'b0;

            n_marks = $urandom_range(0, 4);
            for (int i = 0; i < n_marks; i++) begin
                if (nest_rows.size() != 0 && $urandom_range(0, 3) == 0) begin
                    // Clear a placed nest.
                    k = $urandom_range(0, nest_rows.size() - 1);
                    send_beat(gndf_pkg::KIND_MARK, nest_rows[k], nest_cols[k], 1'b0);
                    nest_rows.delete(k);
                    nest_cols.delete(k);
                end else if (nest_rows.size() < MAX_NESTS) begin
                    r = $urandom_range(0, LAST);
                    c = $urandom_range(0, LAST);
                    send_beat(gndf_pkg::KIND_MARK, r, c, 1'b1);
                    nest_rows.push_back(r);
                    nest_cols.push_back(c);
                end else begin
                    send_beat(gndf_pkg::KIND_MARK, $urandom_range(0, LAST),
                              $urandom_range(0, LAST), 1'b0);
                end
                sent++;
            end

            if ($urandom_range(0, 5) == 0) begin
                send_beat(KIND_UNUSED, $urandom_range(0, LAST), $urandom_range(0, LAST),
                          1'($urandom_range(0, 1)));
            end

            if ($urandom_range(0, 4) != 0) begin
                send_beat(gndf_pkg::KIND_RUN, $urandom_range(0, LAST), $urandom_range(0, LAST),
                          1'($urandom_range(0, 1)));
                sent++;
            end

            if (group == 2) begin
                // Wait out any run in flight so the hold lands on the reads.
                i_in_valid <= 1'b0;
                while (chk_pending != 0) @(negedge i_clk);
                // Hold the receiver off and offer ten reads, so the block backs up.
                long_hold_req = 1'b1;
                for (int i = 0; i < 10; i++) begin
                    read_cell($urandom_range(0, 1));
                    sent++;
                end
            end

            k = $urandom_range(3, 8);
            for (int i = 0; i < k; i++) begin
                read_cell($urandom_range(0, 1));
                sent++;
            end

            if (group == 4) begin
                // Pause the sender until every result is back.
                i_in_valid <= 1'b0;
                while (chk_pending != 0) @(negedge i_clk);
            end
            group++;
        end

        // Drain: drop valid, wait for the last result, then wait out the tail.
        i_in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/gndf_pkg.sv
hw/rtl/grid_nest_distance_field.sv
dv/gndf_field_checker.sv
dv/tb_top.sv
